[rtl/quarter_wave_sine_cosine_unit_macros.svh]
// ----------------------------------------------------------------------------
// Quarter-wave sine/cosine unit assertion macros
// Shared property wrappers on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUARTER_WAVE_SINE_COSINE_UNIT_MACROS_SVH
`define QUARTER_WAVE_SINE_COSINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define QWSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QWSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qwsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine/cosine package
// Fixed widths, constants and the table point function.
// ----------------------------------------------------------------------------
package qwsc_pkg;

    localparam int ANGLE_W    = 16;
    localparam int PHASE_W    = 14;
    localparam int FOLD_W     = 15;     // folded phase, 0..0x4000
    localparam int ROM_W      = 17;     // table point, 0..65536
    localparam int VALUE_W    = 18;     // signed 2.16 result

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [FOLD_W-1:0]  FOLD_MAX     = 15'h4000;
    localparam longint HALF_PI_FX = 102943;
    localparam longint ONE_FX     = 65536;

    typedef logic [1:0] quad_t;

    // Fifth-order sine series in 16.16, clamped to 0..1.0.
    function automatic logic [ROM_W-1:0] rom_value(input longint x);
        longint x2;
        longint x3;
        longint x5;
        longint y;
        x2 = (x * x) >> 16;
        x3 = (x2 * x) >> 16;
        x5 = (x3 * x2) >> 16;
        y  = x - x3 / 6 + x5 / 120;
        if (y < 0)
        begin
            y = 0;
        end
        if (y > ONE_FX)
        begin
            y = ONE_FX;
        end
        return ROM_W'(y);
    endfunction

endpackage

[rtl/quarter_wave_sine_cosine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine/cosine unit
// Table lookup with linear interpolation, five register stages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, angle, req_type): angle is an unsigned
//   16-bit fraction of a full turn; req_type 0 asks for sine, 1 for cosine.
//   Output channel (out_valid, out_stall, value): value is the signed 2.16
//   result, -1.0 .. +1.0.
//   A request is taken on a clock edge with valid high and stall low.
//   out_valid rises when the request reaches the last stage register, where
//   the result can be taken; one request enters every cycle while in_stall
//   is low. The stages are fold, index multiply, table read, difference
//   multiply, and add/negate.
//   Each stage has its own valid bit and moves when the stage after it is
//   empty or moving, so bubbles close up while the receiver stalls. When the
//   receiver holds out_stall while out_valid is high, value holds and in_stall
//   rises once all five stages are full.
//   Reset clears every valid bit; the pipeline comes out empty. No state is
//   kept between requests.
// ----------------------------------------------------------------------------
`include "quarter_wave_sine_cosine_unit_macros.svh"

module quarter_wave_sine_cosine_unit #(
    parameter int TABLE_POINTS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [qwsc_pkg::ANGLE_W-1:0]       angle,
    input  logic                               req_type,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [qwsc_pkg::VALUE_W-1:0] value
);

    localparam int IDX_W = $clog2(TABLE_POINTS + 1);
    localparam int S_W   = qwsc_pkg::PHASE_W + IDX_W;
    localparam int FW    = qwsc_pkg::FOLD_W;
    localparam int RW    = qwsc_pkg::ROM_W;
    localparam int VW    = qwsc_pkg::VALUE_W;
    localparam int PW    = VW + FW;

    // Quarter-wave table, built at elaboration.
    logic [RW-1:0] rom_mem [TABLE_POINTS+1];

    for (genvar gi = 0; gi <= TABLE_POINTS; gi++)
    begin : g_rom
        localparam longint X = (longint'(gi) * qwsc_pkg::HALF_PI_FX) / TABLE_POINTS;
        assign rom_mem[gi] = qwsc_pkg::rom_value(X);
    end

    // Stage valid bits and readiness.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || !out_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = !rdy1;
    assign out_valid = v5_reg;

    // Stage 1: add quarter turn for cosine, fold into the first quadrant.
    logic [qwsc_pkg::ANGLE_W-1:0] turn;
    qwsc_pkg::quad_t               quad;
    logic [FW-1:0]                 phase;
    logic [FW-1:0]                 fold_next;

    logic [FW-1:0] fold_reg;
    logic          neg1_reg;

    always_comb
    begin
        turn  = req_type ? (angle + qwsc_pkg::QUARTER_TURN) : angle;
        quad  = turn[qwsc_pkg::ANGLE_W-1 -: 2];
        phase = {1'b0, turn[qwsc_pkg::PHASE_W-1:0]};
        fold_next = quad[0] ? (qwsc_pkg::FOLD_MAX - phase) : phase;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            fold_reg <= fold_next;
            neg1_reg <= quad[1];
        end
    end

    // Stage 2: scale to table points, split into index and fraction.
    logic [S_W-1:0]             scaled;
    logic [IDX_W-1:0]           idx_next;
    logic [IDX_W-1:0]           nxt_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           nxt_reg;
    logic [qwsc_pkg::PHASE_W-1:0] frac2_reg;
    logic                       neg2_reg;

    always_comb
    begin
        scaled   = S_W'(fold_reg) * S_W'(TABLE_POINTS);
        idx_next = scaled[S_W-1:qwsc_pkg::PHASE_W];
        nxt_next = (idx_next == IDX_W'(TABLE_POINTS)) ? idx_next : idx_next + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            idx_reg   <= idx_next;
            nxt_reg   <= nxt_next;
            frac2_reg <= scaled[qwsc_pkg::PHASE_W-1:0];
            neg2_reg  <= neg1_reg;
        end
    end

    // Stage 3: read both neighbor points.
    logic [RW-1:0]                a3_reg;
    logic [RW-1:0]                b3_reg;
    logic [qwsc_pkg::PHASE_W-1:0] frac3_reg;
    logic                         neg3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            a3_reg    <= rom_mem[idx_reg];
            b3_reg    <= rom_mem[nxt_reg];
            frac3_reg <= frac2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    // Stage 4: weight the neighbor difference by the fraction.
    logic signed [VW-1:0] diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic [RW-1:0]        a4_reg;
    logic                 neg4_reg;

    always_comb
    begin
        diff      = $signed({1'b0, b3_reg}) - $signed({1'b0, a3_reg});
        prod_next = PW'(diff) * PW'($signed({1'b0, frac3_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            prod_reg <= prod_next;
            a4_reg   <= a3_reg;
            neg4_reg <= neg3_reg;
        end
    end

    // Stage 5: arithmetic shift floors the step, then add and negate.
    logic signed [PW-1:0] step;
    logic signed [VW-1:0] mag;
    logic signed [VW-1:0] value_next;
    logic signed [VW-1:0] value_reg;

    always_comb
    begin
        step       = prod_reg >>> qwsc_pkg::PHASE_W;
        mag        = $signed({1'b0, a4_reg}) + VW'(step);
        value_next = neg4_reg ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Assertions.
    `QWSC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_reg,
        "accepted request did not enter the first stage")
    `QWSC_ASSERT_NEXT(a_stage4_moves, v4_reg && rdy5, v5_reg,
        "request lost between the last two stages")
    `QWSC_ASSERT_NOW(a_idx_range, v2_reg,
        idx_reg <= IDX_W'(TABLE_POINTS) && nxt_reg <= IDX_W'(TABLE_POINTS),
        "table index past the last point")
    `QWSC_ASSERT_NOW(a_end_frac, v2_reg && idx_reg == IDX_W'(TABLE_POINTS),
        frac2_reg == '0, "nonzero fraction at the last table point")
    `QWSC_ASSERT_NOW(a_value_range, out_valid,
        value >= -$signed(VW'(qwsc_pkg::ONE_FX)) && value <= $signed(VW'(qwsc_pkg::ONE_FX)),
        "result outside -1.0 .. +1.0")

endmodule
